@@ rtl/core/kce_pkg.sv @@
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types and constants of the keypad calculator engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kce_pkg;

  localparam int unsigned EntryW    = 54;  // holds any 16-digit decimal entry
  localparam int unsigned MaxDigits = 16;
  localparam int unsigned DigitCntW = 5;
  localparam int unsigned FrameW    = 28;  // carry, hidden, 23 frac, G R S
  localparam int unsigned ExpW      = 11;  // signed working exponent

  typedef enum logic [1:0] {
    KEY_DIGIT  = 2'd0,
    KEY_OPER   = 2'd1,
    KEY_EQUALS = 2'd2,
    KEY_CLEAR  = 2'd3
  } key_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } oper_e;

  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_SECOND = 2'd1,
    MODE_RESULT = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CV_SHOW,
    CV_FIRST,
    CV_OPERAND
  } conv_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_CONV,
    T_CALC,
    T_FIN,
    T_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ALIGN,
    F_PRENORM,
    F_MUL,
    F_DIV,
    F_NORM,
    F_ROUND
  } fpu_state_e;

  typedef struct packed {
    logic  start;
    oper_e op;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bits;
  } fpu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/core/keypad_calculator_engine.sv @@
// ----------------------------------------------------------------------------
// keypad_calculator_engine
// Four-function calculator fed one key per word, single-precision results.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | word
//  in      | input     | in_valid_i / in_ready_o   | opcode, digit_value, operator_code
//  out     | output    | out_valid_o / out_ready_i | mode, shown_value, first_operand,
//          |           |                           | pending_operator
//
// One key at a time. A key without arithmetic runs the entry-to-single
// shifter (one bit a cycle over 54 bits) once or twice. Arithmetic adds
// the serial unit: 24 multiply, 27 divide or up to 27 align steps, up to
// 23 prenormalize steps for a denormal first operand, and normalize steps
// (about 150 for results deep in the denormals). Reset: first-entry mode, zero entry.
// A stalled output word holds in its register; the next key waits for idle.
`timescale 1ns / 1ps
`default_nettype none

module keypad_calculator_engine #(
  parameter int unsigned MAX_DIGITS = kce_pkg::MaxDigits
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  digit_value_i,
  input  wire logic [1:0]  operator_code_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       mode_o,
  output logic [31:0]      shown_value_o,
  output logic [31:0]      first_operand_o,
  output logic [1:0]       pending_operator_o
);

  localparam int unsigned EW = kce_pkg::EntryW;
  localparam int unsigned DW = kce_pkg::DigitCntW;

  kce_pkg::top_state_e st_q, st_d;
  kce_pkg::mode_e      mode_q, mode_d;
  kce_pkg::oper_e      oper_q, oper_d;
  kce_pkg::oper_e      kop_q, kop_d;
  kce_pkg::key_e       key_q, key_d;
  kce_pkg::conv_e      cv_q, cv_d;
  logic [EW-1:0]       entry_q, entry_d;
  logic [DW-1:0]       digits_q, digits_d;
  logic [31:0]         first_q, first_d;
  logic [31:0]         result_q, result_d;
  logic [31:0]         shown_q, shown_d;

  logic                out_valid_q, out_valid_d;
  kce_pkg::mode_e      out_mode_q, out_mode_d;
  logic [31:0]         out_shown_q, out_shown_d;
  logic [31:0]         out_first_q, out_first_d;
  kce_pkg::oper_e      out_oper_q, out_oper_d;

  logic                conv_start;
  logic                conv_done;
  logic [31:0]         conv_bits;
  kce_pkg::fpu_req_t   fpu_req;
  kce_pkg::fpu_rsp_t   fpu_rsp;

  logic                wipe;
  logic [EW-1:0]       cur_entry;
  logic [DW-1:0]       cur_digits;

  kce_i2f u_i2f (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (entry_q),
    .done_o  (conv_done),
    .bits_o  (conv_bits)
  );

  kce_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .a_i    (first_q),
    .b_i    (conv_bits),
    .rsp_o  (fpu_rsp)
  );

  always_comb begin
    st_d        = st_q;
    mode_d      = mode_q;
    oper_d      = oper_q;
    kop_d       = kop_q;
    key_d       = key_q;
    cv_d        = cv_q;
    entry_d     = entry_q;
    digits_d    = digits_q;
    first_d     = first_q;
    result_d    = result_q;
    shown_d     = shown_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_mode_d  = out_mode_q;
    out_shown_d = out_shown_q;
    out_first_d = out_first_q;
    out_oper_d  = out_oper_q;
    conv_start  = 1'b0;
    fpu_req.start = 1'b0;
    fpu_req.op    = oper_q;
    in_ready_o  = (st_q == kce_pkg::T_IDLE);

    wipe       = (mode_q == kce_pkg::MODE_RESULT) || (mode_q == kce_pkg::MODE_ERROR);
    cur_entry  = wipe ? '0 : entry_q;
    cur_digits = wipe ? DW'(1) : digits_q;

    unique case (st_q)
      kce_pkg::T_IDLE: begin
        if (in_valid_i) begin
          key_d = kce_pkg::key_e'(opcode_i);
          kop_d = kce_pkg::oper_e'(operator_code_i);
          st_d  = kce_pkg::T_FIN;
          unique case (kce_pkg::key_e'(opcode_i))
            kce_pkg::KEY_DIGIT: begin
              if (digit_value_i <= 4'd9) begin
                if (wipe) begin
                  mode_d   = kce_pkg::MODE_FIRST;
                  first_d  = '0;
                  result_d = '0;
                  oper_d   = kce_pkg::OP_ADD;
                end
                if (cur_entry == '0) begin
                  entry_d  = EW'(digit_value_i);
                  digits_d = DW'(1);
                end else if (cur_digits < DW'(MAX_DIGITS)) begin
                  entry_d  = (cur_entry << 3) + (cur_entry << 1) + EW'(digit_value_i);
                  digits_d = cur_digits + 1'b1;
                end else begin
                  entry_d  = cur_entry;
                  digits_d = cur_digits;
                end
              end
            end
            kce_pkg::KEY_OPER: begin
              unique case (mode_q)
                kce_pkg::MODE_FIRST: begin
                  conv_start = 1'b1;
                  cv_d       = kce_pkg::CV_FIRST;
                  st_d       = kce_pkg::T_CONV;
                end
                kce_pkg::MODE_RESULT: begin
                  first_d  = result_q;
                  oper_d   = kce_pkg::oper_e'(operator_code_i);
                  mode_d   = kce_pkg::MODE_SECOND;
                  entry_d  = '0;
                  digits_d = DW'(1);
                end
                kce_pkg::MODE_SECOND: begin
                  conv_start = 1'b1;
                  cv_d       = kce_pkg::CV_OPERAND;
                  st_d       = kce_pkg::T_CONV;
                end
                default: ;
              endcase
            end
            kce_pkg::KEY_EQUALS: begin
              if (mode_q == kce_pkg::MODE_SECOND) begin
                conv_start = 1'b1;
                cv_d       = kce_pkg::CV_OPERAND;
                st_d       = kce_pkg::T_CONV;
              end
            end
            default: begin
              mode_d   = kce_pkg::MODE_FIRST;
              entry_d  = '0;
              digits_d = DW'(1);
              first_d  = '0;
              result_d = '0;
              oper_d   = kce_pkg::OP_ADD;
            end
          endcase
        end
      end
      kce_pkg::T_CONV: begin
        if (conv_done) begin
          unique case (cv_q)
            kce_pkg::CV_FIRST: begin
              first_d  = conv_bits;
              oper_d   = kop_q;
              mode_d   = kce_pkg::MODE_SECOND;
              entry_d  = '0;
              digits_d = DW'(1);
              st_d     = kce_pkg::T_FIN;
            end
            kce_pkg::CV_OPERAND: begin
              // divide by a zero entry: error, entry kept
              if (oper_q == kce_pkg::OP_DIV && entry_q == '0) begin
                mode_d = kce_pkg::MODE_ERROR;
                st_d   = kce_pkg::T_FIN;
              end else begin
                fpu_req.start = 1'b1;
                st_d          = kce_pkg::T_CALC;
              end
            end
            default: begin
              shown_d = conv_bits;
              st_d    = kce_pkg::T_DONE;
            end
          endcase
        end
      end
      kce_pkg::T_CALC: begin
        if (fpu_rsp.done) begin
          result_d = fpu_rsp.bits;
          entry_d  = '0;
          digits_d = DW'(1);
          st_d     = kce_pkg::T_FIN;
          if (fpu_rsp.bits[30:23] == 8'hFF) begin
            mode_d = kce_pkg::MODE_ERROR;
          end else if (key_q == kce_pkg::KEY_OPER) begin
            first_d = fpu_rsp.bits;
            oper_d  = kop_q;
            mode_d  = kce_pkg::MODE_SECOND;
          end else begin
            mode_d = kce_pkg::MODE_RESULT;
          end
        end
      end
      kce_pkg::T_FIN: begin
        if (mode_q == kce_pkg::MODE_FIRST || mode_q == kce_pkg::MODE_SECOND) begin
          conv_start = 1'b1;
          cv_d       = kce_pkg::CV_SHOW;
          st_d       = kce_pkg::T_CONV;
        end else begin
          shown_d = (mode_q == kce_pkg::MODE_RESULT) ? result_q : 32'd0;
          st_d    = kce_pkg::T_DONE;
        end
      end
      kce_pkg::T_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_mode_d  = mode_q;
          out_shown_d = shown_q;
          out_first_d = first_q;
          out_oper_d  = oper_q;
          st_d        = kce_pkg::T_IDLE;
        end
      end
      default: st_d = kce_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= kce_pkg::T_IDLE;
      mode_q      <= kce_pkg::MODE_FIRST;
      oper_q      <= kce_pkg::OP_ADD;
      entry_q     <= '0;
      digits_q    <= DW'(1);
      first_q     <= '0;
      result_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      mode_q      <= mode_d;
      oper_q      <= oper_d;
      entry_q     <= entry_d;
      digits_q    <= digits_d;
      first_q     <= first_d;
      result_q    <= result_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kop_q       <= kop_d;
    key_q       <= key_d;
    cv_q        <= cv_d;
    shown_q     <= shown_d;
    out_mode_q  <= out_mode_d;
    out_shown_q <= out_shown_d;
    out_first_q <= out_first_d;
    out_oper_q  <= out_oper_d;
  end

  assign out_valid_o        = out_valid_q;
  assign mode_o             = out_mode_q;
  assign shown_value_o      = out_shown_q;
  assign first_operand_o    = out_first_q;
  assign pending_operator_o = out_oper_q;

endmodule

`default_nettype wire

@@ rtl/core/kce_i2f.sv @@
// ----------------------------------------------------------------------------
// kce_i2f
// Unsigned integer entry to single precision, one shift per cycle,
// round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kce_i2f (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [kce_pkg::EntryW-1:0]  value_i,
  output logic                             done_o,
  output logic [31:0]                      bits_o
);

  localparam int unsigned EW = kce_pkg::EntryW;
  localparam int unsigned PW = $clog2(EW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [EW-1:0] sh_q, sh_d;
  logic [PW-1:0] p_q, p_d;
  logic [31:0]   bits_q, bits_d;
  logic          rnd;
  logic [7:0]    expf;
  logic [30:0]   packed_v;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sh_d   = sh_q;
    p_d    = p_q;
    bits_d = bits_q;
    // hidden bit sits at the top of the shifter
    rnd      = sh_q[EW-25] & ((|sh_q[EW-26:0]) | sh_q[EW-24]);
    expf     = 8'd127 + 8'(p_q);
    packed_v = {expf, sh_q[EW-2:EW-24]} + 31'(rnd);
    if (start_i) begin
      busy_d = 1'b1;
      sh_d   = value_i;
      p_d    = PW'(EW - 1);
    end else if (busy_q) begin
      if (sh_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        bits_d = '0;
      end else if (sh_q[EW-1]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        bits_d = {1'b0, packed_v};
      end else begin
        sh_d = {sh_q[EW-2:0], 1'b0};
        p_d  = p_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    p_q    <= p_d;
    bits_q <= bits_d;
  end

  assign done_o = done_q;
  assign bits_o = bits_q;

endmodule

`default_nettype wire

@@ rtl/core/kce_fpu.sv @@
// ----------------------------------------------------------------------------
// kce_fpu
// Serial single-precision add, subtract, multiply and divide with
// denormals and round to nearest even.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kce_fpu (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kce_pkg::fpu_req_t req_i,
  input  wire logic [31:0]       a_i,
  input  wire logic [31:0]       b_i,
  output kce_pkg::fpu_rsp_t      rsp_o
);

  localparam int unsigned FW = kce_pkg::FrameW;
  localparam int unsigned XW = kce_pkg::ExpW;

  kce_pkg::fpu_state_e st_q, st_d;
  kce_pkg::oper_e      op_q, op_d;
  logic                done_q, done_d;
  logic [31:0]         res_q, res_d;
  logic                sgn_q, sgn_d;
  logic                zs_q, zs_d;
  logic                zr_q, zr_d;
  logic                sub_q, sub_d;
  logic signed [XW-1:0] er_q, er_d, ea_q, ea_d, eb_q, eb_d;
  logic [23:0]         ma_q, ma_d, mb_q, mb_d;
  logic [FW-1:0]       frame_q, frame_d, aux_q, aux_d;
  logic [47:0]         prod_q, prod_d;
  logic [24:0]         rem_q, rem_d;
  logic [4:0]          cnt_q, cnt_d;

  logic [7:0]    a_exp, b_exp, a_ee, b_ee, diff;
  logic [23:0]   a_man, b_man;
  logic          a_big, b_neg, rnd, ge;
  logic [FW-1:0] sum;
  logic [24:0]   upper, remsub;
  logic [7:0]    expf;
  logic [30:0]   packed_v;

  always_comb begin
    st_d    = st_q;
    op_d    = op_q;
    done_d  = 1'b0;
    res_d   = res_q;
    sgn_d   = sgn_q;
    zs_d    = zs_q;
    zr_d    = zr_q;
    sub_d   = sub_q;
    er_d    = er_q;
    ea_d    = ea_q;
    eb_d    = eb_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    frame_d = frame_q;
    aux_d   = aux_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;

    a_exp = a_i[30:23];
    b_exp = b_i[30:23];
    a_man = {|a_exp, a_i[22:0]};
    b_man = {|b_exp, b_i[22:0]};
    a_ee  = (a_exp == 8'd0) ? 8'd1 : a_exp;
    b_ee  = (b_exp == 8'd0) ? 8'd1 : b_exp;
    a_big = a_i[30:0] >= b_i[30:0];
    b_neg = b_i[31] ^ (req_i.op == kce_pkg::OP_SUB);
    diff  = a_big ? (a_ee - b_ee) : (b_ee - a_ee);
    sum   = sub_q ? (frame_q - aux_q) : (frame_q + aux_q);
    upper = {1'b0, prod_q[47:24]} + (mb_q[0] ? {1'b0, ma_q} : 25'd0);
    ge    = rem_q >= {1'b0, mb_q};
    remsub = ge ? (rem_q - {1'b0, mb_q}) : rem_q;
    rnd   = frame_q[2] & (frame_q[1] | frame_q[0] | frame_q[3]);
    expf  = frame_q[26] ? er_q[7:0] : 8'd0;
    packed_v = {expf, frame_q[25:3]} + 31'(rnd);

    unique case (st_q)
      kce_pkg::F_IDLE: begin
        if (req_i.start) begin
          op_d = req_i.op;
          zr_d = 1'b0;
          if (req_i.op == kce_pkg::OP_ADD || req_i.op == kce_pkg::OP_SUB) begin
            sub_d = a_i[31] ^ b_neg;
            zs_d  = a_i[31] & b_neg;
            if (a_big) begin
              sgn_d   = a_i[31];
              frame_d = {1'b0, a_man, 3'b000};
              aux_d   = {1'b0, b_man, 3'b000};
              er_d    = XW'(a_ee);
            end else begin
              sgn_d   = b_neg;
              frame_d = {1'b0, b_man, 3'b000};
              aux_d   = {1'b0, a_man, 3'b000};
              er_d    = XW'(b_ee);
            end
            // beyond 27 places the smaller operand is pure sticky
            cnt_d = (diff > 8'd27) ? 5'd27 : diff[4:0];
            st_d  = kce_pkg::F_ALIGN;
          end else begin
            sgn_d = a_i[31] ^ b_i[31];
            ea_d  = XW'(a_ee);
            eb_d  = XW'(b_ee);
            ma_d  = a_man;
            mb_d  = b_man;
            if (a_man == 24'd0 || (req_i.op == kce_pkg::OP_MUL && b_man == 24'd0)) begin
              zr_d = 1'b1;
              st_d = kce_pkg::F_ROUND;
            end else begin
              st_d = kce_pkg::F_PRENORM;
            end
          end
        end
      end
      kce_pkg::F_ALIGN: begin
        if (cnt_q != 5'd0) begin
          aux_d = {1'b0, aux_q[FW-1:2], aux_q[1] | aux_q[0]};
          cnt_d = cnt_q - 1'b1;
        end else begin
          frame_d = sum;
          if (sum == '0) begin
            zr_d  = 1'b1;
            sgn_d = zs_q;
          end
          st_d = kce_pkg::F_NORM;
        end
      end
      kce_pkg::F_PRENORM: begin
        if (ma_q[23]) begin
          if (op_q == kce_pkg::OP_MUL) begin
            er_d   = ea_q + eb_q - XW'(127);
            prod_d = '0;
            cnt_d  = 5'd24;
            st_d   = kce_pkg::F_MUL;
          end else begin
            er_d    = ea_q - eb_q + XW'(127);
            rem_d   = {1'b0, ma_q};
            frame_d = '0;
            cnt_d   = 5'd27;
            st_d    = kce_pkg::F_DIV;
          end
        end else begin
          ma_d = {ma_q[22:0], 1'b0};
          ea_d = ea_q - XW'(1);
        end
      end
      kce_pkg::F_MUL: begin
        if (cnt_q != 5'd0) begin
          prod_d = {upper, prod_q[23:1]};
          mb_d   = {1'b0, mb_q[23:1]};
          cnt_d  = cnt_q - 1'b1;
        end else begin
          frame_d = {prod_q[47:21], |prod_q[20:0]};
          st_d    = kce_pkg::F_NORM;
        end
      end
      kce_pkg::F_DIV: begin
        if (cnt_q != 5'd0) begin
          rem_d   = {remsub[23:0], 1'b0};
          frame_d = {frame_q[FW-2:0], ge};
          cnt_d   = cnt_q - 1'b1;
        end else begin
          frame_d = {frame_q[FW-1:1], frame_q[0] | (rem_q != 25'd0)};
          st_d    = kce_pkg::F_NORM;
        end
      end
      kce_pkg::F_NORM: begin
        if (zr_q) begin
          st_d = kce_pkg::F_ROUND;
        end else if (frame_q[27]) begin
          frame_d = {1'b0, frame_q[FW-1:2], frame_q[1] | frame_q[0]};
          er_d    = er_q + XW'(1);
        end else if (!frame_q[26] && er_q > XW'(1)) begin
          frame_d = {frame_q[FW-2:0], 1'b0};
          er_d    = er_q - XW'(1);
        end else if (er_q < XW'(1)) begin
          // underflow: denormalize toward the minimum exponent
          frame_d = {1'b0, frame_q[FW-1:2], frame_q[1] | frame_q[0]};
          er_d    = er_q + XW'(1);
        end else begin
          st_d = kce_pkg::F_ROUND;
        end
      end
      kce_pkg::F_ROUND: begin
        if (zr_q) begin
          res_d = {sgn_q, 31'd0};
        end else if (er_q >= XW'(255) || packed_v[30:23] == 8'hFF) begin
          res_d = {sgn_q, 8'hFF, 23'd0};
        end else begin
          res_d = {sgn_q, packed_v};
        end
        done_d = 1'b1;
        st_d   = kce_pkg::F_IDLE;
      end
      default: st_d = kce_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= kce_pkg::F_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    res_q   <= res_d;
    sgn_q   <= sgn_d;
    zs_q    <= zs_d;
    zr_q    <= zr_d;
    sub_q   <= sub_d;
    er_q    <= er_d;
    ea_q    <= ea_d;
    eb_q    <= eb_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    frame_q <= frame_d;
    aux_q   <= aux_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.bits = res_q;

endmodule

`default_nettype wire
